// File: rtl/tws_pkg.sv
// ----------------------------------------------------------------------------
// Three-wire serial master package
// Shared request codes, command bytes and the result word type.
// ----------------------------------------------------------------------------
package tws_pkg;

	localparam int DEFAULT_BURST_BYTES = 8;

	localparam logic [2:0] REQ_TICK     = 3'd0;
	localparam logic [2:0] REQ_WRITE    = 3'd1;
	localparam logic [2:0] REQ_READ     = 3'd2;
	localparam logic [2:0] REQ_BURST_WR = 3'd3;
	localparam logic [2:0] REQ_BURST_RD = 3'd4;

	localparam logic [1:0] KIND_WRITE    = 2'd0;
	localparam logic [1:0] KIND_READ     = 2'd1;
	localparam logic [1:0] KIND_BURST_WR = 2'd2;
	localparam logic [1:0] KIND_BURST_RD = 2'd3;

	localparam logic [7:0] CMD_WRITE_BASE = 8'h80;
	localparam logic [7:0] CMD_READ_BIT   = 8'h01;
	localparam logic [7:0] CMD_BURST_WR   = 8'hBE;
	localparam logic [7:0] CMD_BURST_RD   = 8'hBF;

	typedef struct packed {
		logic       chip_enable;
		logic       serial_clock;
		logic       io_out;
		logic       io_drive;
		logic [7:0] read_data;
		logic       read_valid;
		logic       data_taken;
		logic       busy_res;
		logic       done_res;
	} res_t;

endpackage

// File: rtl/tws_engine.sv
// ----------------------------------------------------------------------------
// Three-wire serial engine
// Holds the transaction state and advances it by one tick per accepted word.
// ----------------------------------------------------------------------------
module tws_engine
	import tws_pkg::*;
#(
	parameter int BURST_BYTES = DEFAULT_BURST_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [2:0] req_type,
	input  logic [4:0] reg_addr,
	input  logic [7:0] write_data,
	input  logic       io_in,
	output res_t       res
);

	localparam int CW = $clog2(BURST_BYTES + 2);
	localparam logic [CW-1:0] TOTAL_BURST  = CW'(BURST_BYTES + 1);
	localparam logic [CW-1:0] TOTAL_SINGLE = CW'(2);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SETUP,
		PH_PULSE,
		PH_FINISH
	} phase_t;

	phase_t        phase_q, phase_d;
	logic [1:0]    kind_q, kind_d;
	logic [2:0]    bit_q, bit_d;
	logic [CW-1:0] byte_q, byte_d;
	logic [7:0]    sout_q, sout_d;
	logic [7:0]    sin_q, sin_d;
	logic          ce_q, ce_d;
	logic          clk_q, clk_d;
	logic          dat_q, dat_d;
	logic          drv_q, drv_d;
	logic          rvalid, taken, busy, done;
	logic [7:0]    rdata;
	logic [CW-1:0] total;

	always_comb begin
		phase_d = phase_q;
		kind_d  = kind_q;
		bit_d   = bit_q;
		byte_d  = byte_q;
		sout_d  = sout_q;
		sin_d   = sin_q;
		ce_d    = ce_q;
		clk_d   = clk_q;
		dat_d   = dat_q;
		drv_d   = drv_q;
		rvalid  = 1'b0;
		taken   = 1'b0;
		busy    = 1'b0;
		done    = 1'b0;
		rdata   = 8'h00;
		total   = (kind_q >= KIND_BURST_WR) ? TOTAL_BURST : TOTAL_SINGLE;
		case (phase_q)
			PH_SETUP: begin
				clk_d = 1'b0;
				if (byte_q == '0 || kind_q[0] == 1'b0) begin
					if (bit_q == 3'd0 && byte_q != '0) begin
						sout_d = write_data;
						taken  = 1'b1;
					end
					dat_d = sout_d[bit_q];
					drv_d = 1'b1;
				end else begin
					sin_d[bit_q] = io_in;
					dat_d = 1'b1;
					drv_d = 1'b0;
					if (bit_q == 3'd7) begin
						rvalid = 1'b1;
						rdata  = sin_d;
					end
				end
				phase_d = PH_PULSE;
				busy    = 1'b1;
			end
			PH_PULSE: begin
				clk_d = 1'b1;
				busy  = 1'b1;
				bit_d = bit_q + 3'd1;
				if (bit_q == 3'd7) begin
					byte_d  = byte_q + CW'(1);
					phase_d = (byte_d >= total) ? PH_FINISH : PH_SETUP;
				end else begin
					phase_d = PH_SETUP;
				end
			end
			PH_FINISH: begin
				ce_d    = 1'b0;
				clk_d   = 1'b0;
				dat_d   = 1'b1;
				drv_d   = 1'b0;
				done    = 1'b1;
				phase_d = PH_IDLE;
			end
			default: begin
				phase_d = PH_IDLE;
				if (req_type inside {[REQ_WRITE:REQ_BURST_RD]}) begin
					kind_d = 2'(req_type - REQ_WRITE);
					case (kind_d)
						KIND_WRITE: sout_d = {2'b00, reg_addr, 1'b0} | CMD_WRITE_BASE;
						KIND_READ: begin
							sout_d = {2'b00, reg_addr, 1'b0} | CMD_WRITE_BASE | CMD_READ_BIT;
						end
						KIND_BURST_WR: sout_d = CMD_BURST_WR;
						default: sout_d = CMD_BURST_RD;
					endcase
					bit_d   = 3'd0;
					byte_d  = '0;
					sin_d   = 8'h00;
					ce_d    = 1'b1;
					clk_d   = 1'b0;
					dat_d   = 1'b0;
					drv_d   = 1'b1;
					phase_d = PH_SETUP;
					busy    = 1'b1;
				end else begin
					ce_d  = 1'b0;
					clk_d = 1'b0;
					dat_d = 1'b1;
					drv_d = 1'b0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			kind_q  <= KIND_WRITE;
			bit_q   <= 3'd0;
			byte_q  <= '0;
			sout_q  <= 8'h00;
			sin_q   <= 8'h00;
			ce_q    <= 1'b0;
			clk_q   <= 1'b0;
			dat_q   <= 1'b1;
			drv_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			bit_q   <= bit_d;
			byte_q  <= byte_d;
			sout_q  <= sout_d;
			sin_q   <= sin_d;
			ce_q    <= ce_d;
			clk_q   <= clk_d;
			dat_q   <= dat_d;
			drv_q   <= drv_d;
		end
	end

	always_comb begin
		res.chip_enable  = ce_d;
		res.serial_clock = clk_d;
		res.io_out       = drv_d ? dat_d : 1'b1;
		res.io_drive     = drv_d;
		res.read_data    = rdata;
		res.read_valid   = rvalid;
		res.data_taken   = taken;
		res.busy_res     = busy;
		res.done_res     = done;
	end

endmodule

// File: rtl/tws_skid.sv
// ----------------------------------------------------------------------------
// Three-wire serial result buffer
// Output register with a skid stage so a new word is taken while one waits.
// ----------------------------------------------------------------------------
module tws_skid
	import tws_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic up_valid,
	output logic up_stall,
	input  res_t up_res,
	output logic dn_valid,
	input  logic dn_stall,
	output res_t dn_res
);

	res_t main_q, skid_q;
	logic main_valid_q, skid_valid_q;
	logic main_free;

	assign main_free = !main_valid_q || !dn_stall;
	assign up_stall  = skid_valid_q;
	assign dn_valid  = main_valid_q;
	assign dn_res    = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= up_valid;
			end
		end else if (up_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_valid_q ? skid_q : up_res;
		end else if (up_valid && !skid_valid_q) begin
			skid_q <= up_res;
		end
	end

endmodule

// File: rtl/three_wire_rtc_serial_master_core.sv
// ----------------------------------------------------------------------------
// Three-wire serial master core
// Drives chip enable, serial clock and data of a three-wire link, one tick per
// input word, with single and burst reads and writes sent LSB first.
//
//   Channel | Handshake            | Word
//   --------+----------------------+---------------------------------------
//   input   | in_valid / in_stall  | req_type, reg_addr, write_data, io_in
//   output  | out_valid / out_stall| pin levels, read byte, status flags
//
// Each accepted word yields one registered result word; a word can be accepted
// every cycle while in_stall is low, a rate set by the single engine state update.
// Reset returns the engine to idle with enable and clock low, data released.
// A skid stage holds one extra result, so in_stall rises only when both the
// output register and the skid stage are full.
// ----------------------------------------------------------------------------
module three_wire_rtc_serial_master_core
	import tws_pkg::*;
#(
	parameter int BURST_BYTES = DEFAULT_BURST_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] req_type,
	input  logic [4:0] reg_addr,
	input  logic [7:0] write_data,
	input  logic       io_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       chip_enable,
	output logic       serial_clock,
	output logic       io_out,
	output logic       io_drive,
	output logic [7:0] read_data,
	output logic       read_valid,
	output logic       data_taken,
	output logic       busy_res,
	output logic       done_res
);

	res_t eng_res, out_res;
	logic step;

	assign step = in_valid && !in_stall;

	tws_engine #(
		.BURST_BYTES(BURST_BYTES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.req_type  (req_type),
		.reg_addr  (reg_addr),
		.write_data(write_data),
		.io_in     (io_in),
		.res       (eng_res)
	);

	tws_skid u_skid (
		.clk     (clk),
		.arst_n  (arst_n),
		.up_valid(step),
		.up_stall(in_stall),
		.up_res  (eng_res),
		.dn_valid(out_valid),
		.dn_stall(out_stall),
		.dn_res  (out_res)
	);

	assign chip_enable  = out_res.chip_enable;
	assign serial_clock = out_res.serial_clock;
	assign io_out       = out_res.io_out;
	assign io_drive     = out_res.io_drive;
	assign read_data    = out_res.read_data;
	assign read_valid   = out_res.read_valid;
	assign data_taken   = out_res.data_taken;
	assign busy_res     = out_res.busy_res;
	assign done_res     = out_res.done_res;

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("Input stalled with no result held.");

	a_busy_done_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(busy_res && done_res))
		else $error("Busy and done flagged in the same word.");

	a_read_released: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && read_valid) |-> (!io_drive && chip_enable && !serial_clock))
		else $error("Received byte completed while driving the data pin.");

	a_taken_driving: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && data_taken) |-> (io_drive && chip_enable && busy_res))
		else $error("Write data taken outside a driven setup tick.");

endmodule
